>>> rtl/core/point_rigid_transform_self_filter_top_assert.svh
// Assertion macros shared by the point transform RTL.
// Both macros sample on clk and are switched off while rst_n is low.
`ifndef POINT_RIGID_TRANSFORM_SELF_FILTER_TOP_ASSERT_SVH
`define POINT_RIGID_TRANSFORM_SELF_FILTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRTSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRTSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/prtsf_pkg.sv
package prtsf_pkg;

  // Field widths.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned QUAT_W     = 16;
  localparam int unsigned RADIUS_W   = 31;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W      = 4'd0,
    REG_QUAT_X      = 4'd1,
    REG_QUAT_Y      = 4'd2,
    REG_QUAT_Z      = 4'd3,
    REG_SHIFT_X     = 4'd4,
    REG_SHIFT_Y     = 4'd5,
    REG_SHIFT_Z     = 4'd6,
    REG_SELF_RADIUS = 4'd7
  } prtsf_reg_t;

  // Reset values: identity rotation, no translation, 0.23 m radius.
  localparam logic signed [QUAT_W-1:0]   QUAT_ONE     = 16'sd16384;
  localparam logic [RADIUS_W-1:0]        RADIUS_RESET = 31'd15073;

  // Rotation and translation settings.
  typedef struct packed {
    logic signed [QUAT_W-1:0]  qw;
    logic signed [QUAT_W-1:0]  qx;
    logic signed [QUAT_W-1:0]  qy;
    logic signed [QUAT_W-1:0]  qz;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] sz;
  } prtsf_xform_t;

  // One classified point as it sits in the queue.
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic                      near;
  } prtsf_item_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } prtsf_qstat_t;

endpackage

>>> rtl/core/prtsf_front.sv
module prtsf_front
  import prtsf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  logic [RADIUS_W-1:0]       radius,
  input  prtsf_qstat_t              qstat,
  output logic                      push,
  output prtsf_item_t               push_item
);

  logic                      f1_v_r;
  logic signed [COORD_W-1:0] f1_pt_r [3];
  logic                      f2_v_r;
  logic signed [COORD_W-1:0] f2_pt_r [3];
  logic [2*COORD_W-1:0]      f2_sq_r [3];
  logic [2*RADIUS_W-1:0]     r2_r;
  logic [COORD_W-1:0]        mag [3];
  logic [2*COORD_W-1:0]      dist2;
  logic                      adv;

  // The whole front moves together unless its last stage cannot reach the queue.
  assign adv      = !f2_v_r || !qstat.full;
  assign in_ready = adv;
  assign push     = f2_v_r && !qstat.full;

  // Squared radius follows the radius register in the next cycle.
  always_ff @(posedge clk) begin
    r2_r <= radius * radius;
  end

  // Magnitudes of the coordinates; the most negative value becomes 2^31.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = f1_pt_r[i][COORD_W-1] ? (~f1_pt_r[i] + 1'b1) : f1_pt_r[i];
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  // Input register and squaring stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_valid) begin
        f1_pt_r[0] <= in_point_x;
        f1_pt_r[1] <= in_point_y;
        f1_pt_r[2] <= in_point_z;
      end
      for (int i = 0; i < 3; i++) begin
        f2_pt_r[i] <= f1_pt_r[i];
        f2_sq_r[i] <= mag[i] * mag[i];
      end
    end
  end

  // The three squares sum to less than 2^64, so the compare is exact.
  assign dist2 = f2_sq_r[0] + f2_sq_r[1] + f2_sq_r[2];

  always_comb begin
    push_item.px   = f2_pt_r[0];
    push_item.py   = f2_pt_r[1];
    push_item.pz   = f2_pt_r[2];
    push_item.near = (dist2 <= {2'b00, r2_r});
  end

endmodule

>>> rtl/core/prtsf_queue.sv
`include "point_rigid_transform_self_filter_top_assert.svh"

module prtsf_queue
  import prtsf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  prtsf_item_t  push_item,
  input  logic         pop,
  output prtsf_item_t  pop_item,
  output prtsf_qstat_t qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  prtsf_item_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_item    = mem_r[rd_ptr_r];

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `PRTSF_ASSERT_SAME(a_no_push_full, push, !qstat.full || pop, "push into a full queue")
  `PRTSF_ASSERT_SAME(a_no_pop_empty, pop, !qstat.empty, "pop from an empty queue")
  `PRTSF_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count did not grow")

endmodule

>>> rtl/core/prtsf_back.sv
`include "point_rigid_transform_self_filter_top_assert.svh"

module prtsf_back
  import prtsf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  prtsf_xform_t              xform,
  input  prtsf_qstat_t              qstat,
  input  prtsf_item_t               pop_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic                      out_near_self
);

  // Matrix entries at scale 2^28 reach +/-2^32 for out-of-range quaternions.
  localparam int unsigned MAT_W = 34;
  localparam int unsigned HI_W  = MAT_W + 16;
  localparam int unsigned LO_W  = MAT_W + 17;
  localparam int unsigned HS_W  = HI_W + 2;
  localparam int unsigned LS_W  = LO_W + 2;
  localparam int unsigned TOT_W = 68;
  localparam int unsigned ROT_W = TOT_W - 28;
  localparam int unsigned SUM_W = ROT_W + 1;

  localparam logic signed [MAT_W:0]  MAT_ONE    = 35'sd268435456;
  localparam logic signed [LS_W-1:0] ROUND_HALF = 53'sd134217728;

  logic signed [2*QUAT_W-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [MAT_W-1:0]    m_nxt [3][3];
  logic signed [MAT_W-1:0]    m_r   [3][3];

  logic                       back_en;
  logic signed [COORD_W-1:0]  pt [3];
  logic signed [COORD_W-1:0]  shift [3];

  logic                       a_v_r, b_v_r, c_v_r, out_valid_r;
  prtsf_item_t                a_item_r, b_item_r, c_item_r;
  logic signed [HI_W-1:0]     a_hi_r [3][3];
  logic signed [LO_W-1:0]     a_lo_r [3][3];
  logic signed [HS_W-1:0]     b_hs_r [3];
  logic signed [LS_W-1:0]     b_ls_r [3];
  logic signed [TOT_W-1:0]    c_tot [3];
  logic signed [ROT_W-1:0]    c_rot_r [3];
  logic signed [SUM_W-1:0]    d_sum [3];
  logic [COORD_W-1:0]         out_pt_r [3];
  logic                       out_near_r;

  // Clamp to the signed 32-bit range.
  function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [COORD_W-1:0] res;
    if ((v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1)) begin
      res = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Quaternion products, one register stage after the settings.
  always_ff @(posedge clk) begin
    xx_r <= xform.qx * xform.qx;
    yy_r <= xform.qy * xform.qy;
    zz_r <= xform.qz * xform.qz;
    xy_r <= xform.qx * xform.qy;
    xz_r <= xform.qx * xform.qz;
    yz_r <= xform.qy * xform.qz;
    wx_r <= xform.qw * xform.qx;
    wy_r <= xform.qw * xform.qy;
    wz_r <= xform.qw * xform.qz;
  end

  // Rotation matrix from the products; exact at scale 2^28.
  always_comb begin
    m_nxt[0][0] = MAT_W'(MAT_ONE - ((35'(yy_r) + 35'(zz_r)) <<< 1));
    m_nxt[0][1] = MAT_W'((35'(xy_r) - 35'(wz_r)) <<< 1);
    m_nxt[0][2] = MAT_W'((35'(xz_r) + 35'(wy_r)) <<< 1);
    m_nxt[1][0] = MAT_W'((35'(xy_r) + 35'(wz_r)) <<< 1);
    m_nxt[1][1] = MAT_W'(MAT_ONE - ((35'(xx_r) + 35'(zz_r)) <<< 1));
    m_nxt[1][2] = MAT_W'((35'(yz_r) - 35'(wx_r)) <<< 1);
    m_nxt[2][0] = MAT_W'((35'(xz_r) - 35'(wy_r)) <<< 1);
    m_nxt[2][1] = MAT_W'((35'(yz_r) + 35'(wx_r)) <<< 1);
    m_nxt[2][2] = MAT_W'(MAT_ONE - ((35'(xx_r) + 35'(yy_r)) <<< 1));
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
  end

  // The pipeline moves as one unless the output register holds an untaken result.
  assign back_en = !out_valid_r || out_ready;
  assign pop     = back_en && !qstat.empty;

  assign pt[0]    = pop_item.px;
  assign pt[1]    = pop_item.py;
  assign pt[2]    = pop_item.pz;
  assign shift[0] = xform.sx;
  assign shift[1] = xform.sy;
  assign shift[2] = xform.sz;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      a_v_r       <= pop;
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      out_valid_r <= c_v_r;
    end
  end

  // Row sums: the upper and lower point halves are combined at scale 2^44.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c_tot[r] = (TOT_W'(b_hs_r[r]) <<< 16) + TOT_W'(b_ls_r[r]);
      d_sum[r] = SUM_W'(c_rot_r[r]) + SUM_W'(shift[r]);
    end
  end

  // Partial products, sums, rounding shift, translation, saturation, near bypass.
  always_ff @(posedge clk) begin
    if (back_en) begin
      a_item_r <= pop_item;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          a_hi_r[r][c] <= m_r[r][c] * $signed(pt[c][COORD_W-1:16]);
          a_lo_r[r][c] <= m_r[r][c] * $signed({1'b0, pt[c][15:0]});
        end
      end
      b_item_r <= a_item_r;
      for (int r = 0; r < 3; r++) begin
        b_hs_r[r] <= HS_W'(a_hi_r[r][0]) + HS_W'(a_hi_r[r][1]) + HS_W'(a_hi_r[r][2]);
        b_ls_r[r] <= LS_W'(a_lo_r[r][0]) + LS_W'(a_lo_r[r][1]) + LS_W'(a_lo_r[r][2])
                     + ROUND_HALF;
      end
      c_item_r <= b_item_r;
      for (int r = 0; r < 3; r++) begin
        c_rot_r[r] <= c_tot[r][TOT_W-1:28];
      end
      out_near_r <= c_item_r.near;
      if (c_item_r.near) begin
        out_pt_r[0] <= c_item_r.px;
        out_pt_r[1] <= c_item_r.py;
        out_pt_r[2] <= c_item_r.pz;
      end else begin
        for (int r = 0; r < 3; r++) begin
          out_pt_r[r] <= sat32(d_sum[r]);
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_pt_r[0];
  assign out_y         = out_pt_r[1];
  assign out_z         = out_pt_r[2];
  assign out_near_self = out_near_r;

  `PRTSF_ASSERT_NEXT(a_last_to_out, back_en && c_v_r, out_valid_r, "result lost at output")
  `PRTSF_ASSERT_NEXT(a_stall_hold, !back_en && a_v_r, a_v_r, "item dropped during stall")

endmodule

>>> rtl/core/point_rigid_transform_self_filter_top.sv
// Point transform with self filter: takes one Q16.16 point per transfer and
// returns one result per point, in order. A point within self_radius of the
// origin comes back unchanged with out_near_self set; any other point is
// rotated by the quaternion matrix, shifted, and saturated to Q16.16. The
// block sustains one point per clock while results are taken: a two-stage
// front squares and classifies the point, a queue of QUEUE_DEPTH entries
// decouples it from a four-stage back end whose eighteen partial-product
// multipliers (34x16 and 34x17) handle the rotation. Only an untaken result
// in the output register stalls the back end, so the input only stalls when
// the receiver holds off long enough for the queue to fill. The user must
// write settings through the cfg port while the block is idle; the block
// itself does not enforce this. Settings take effect for the next transfer.
module point_rigid_transform_self_filter_top
  import prtsf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic                      out_near_self,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  prtsf_xform_t          xform_r;
  logic [RADIUS_W-1:0]   radius_r;
  prtsf_qstat_t          qstat;
  logic                  push;
  logic                  pop;
  prtsf_item_t           push_item;
  prtsf_item_t           pop_item;

  // Settings registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xform_r.qw <= QUAT_ONE;
      xform_r.qx <= '0;
      xform_r.qy <= '0;
      xform_r.qz <= '0;
      xform_r.sx <= '0;
      xform_r.sy <= '0;
      xform_r.sz <= '0;
      radius_r   <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUAT_W:      xform_r.qw <= cfg_data[QUAT_W-1:0];
        REG_QUAT_X:      xform_r.qx <= cfg_data[QUAT_W-1:0];
        REG_QUAT_Y:      xform_r.qy <= cfg_data[QUAT_W-1:0];
        REG_QUAT_Z:      xform_r.qz <= cfg_data[QUAT_W-1:0];
        REG_SHIFT_X:     xform_r.sx <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Y:     xform_r.sy <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Z:     xform_r.sz <= cfg_data[COORD_W-1:0];
        REG_SELF_RADIUS: radius_r   <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  prtsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_point_z (in_point_z),
    .radius     (radius_r),
    .qstat      (qstat),
    .push       (push),
    .push_item  (push_item)
  );

  prtsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  prtsf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .xform         (xform_r),
    .qstat         (qstat),
    .pop_item      (pop_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_near_self (out_near_self)
  );

endmodule

>>> verif/point_transform_checker.sv
// Watches both channels of the point transform, predicts every result from
// its own copy of the settings and compares it with what the block returns.
module point_transform_checker
  import prtsf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COORD_W-1:0] out_x,
  input  logic signed [COORD_W-1:0] out_y,
  input  logic signed [COORD_W-1:0] out_z,
  input  logic                      out_near_self,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int                        mismatch_count,
  output int                        results_due
);

  localparam int     MAX_REPORTS = 10;
  localparam longint ONE_Q28     = 64'sd268435456;
  localparam longint ROUND_HALF  = 64'sd134217728;
  localparam longint SAT_MAX     = 64'sd2147483647;
  localparam longint SAT_MIN     = -64'sd2147483648;

  // Shadow copy of the settings, updated from the cfg port.
  logic signed [QUAT_W-1:0]  quat_q [4];
  logic signed [COORD_W-1:0] shift_q [3];
  logic [RADIUS_W-1:0]       radius_q;

  prtsf_item_t expected_points [$];
  prtsf_item_t oldest;
  int          mismatches;
  int          reported;

  // Expected result for one point under the current settings.
  function automatic prtsf_item_t predict_point(input logic signed [COORD_W-1:0] px,
                                                input logic signed [COORD_W-1:0] py,
                                                input logic signed [COORD_W-1:0] pz);
    longint                    p [3];
    longint                    m [3][3];
    longint                    qw, qa, qb, qc, ph, pl, hi, lo, acc, mag;
    logic [63:0]               dist2, r64;
    logic signed [COORD_W-1:0] moved [3];
    prtsf_item_t               res;
    int                        i, j;
    p[0] = px;
    p[1] = py;
    p[2] = pz;

    // Squared distance against squared radius, both exact in 64 bits.
    dist2 = '0;
    for (i = 0; i < 3; i++) begin
      mag = (p[i] < 0) ? -p[i] : p[i];
      dist2 = dist2 + mag * mag;
    end
    r64 = {33'd0, radius_q};

    if (dist2 <= r64 * r64) begin
      res.px   = px;
      res.py   = py;
      res.pz   = pz;
      res.near = 1'b1;
    end else begin
      qw = quat_q[0];
      qa = quat_q[1];
      qb = quat_q[2];
      qc = quat_q[3];

      // Rotation matrix at scale 2^28, quaternion taken as given.
      m[0][0] = ONE_Q28 - 2 * (qb * qb + qc * qc);
      m[0][1] = 2 * (qa * qb) - 2 * (qw * qc);
      m[0][2] = 2 * (qa * qc) + 2 * (qw * qb);
      m[1][0] = 2 * (qa * qb) + 2 * (qw * qc);
      m[1][1] = ONE_Q28 - 2 * (qa * qa + qc * qc);
      m[1][2] = 2 * (qb * qc) - 2 * (qw * qa);
      m[2][0] = 2 * (qa * qc) - 2 * (qw * qb);
      m[2][1] = 2 * (qb * qc) + 2 * (qw * qa);
      m[2][2] = ONE_Q28 - 2 * (qa * qa + qb * qb);

      // Split each coordinate in halves so the sums stay within 64 bits,
      // round once to Q16.16, add the shift and saturate.
      for (i = 0; i < 3; i++) begin
        hi = 0;
        lo = 0;
        for (j = 0; j < 3; j++) begin
          ph = p[j] >>> 16;
          pl = p[j] - ph * 65536;
          hi = hi + m[i][j] * ph;
          lo = lo + m[i][j] * pl;
        end
        hi  = hi + ((lo + ROUND_HALF) >>> 16);
        acc = (hi >>> 12) + shift_q[i];
        if (acc > SAT_MAX) begin
          moved[i] = 32'sh7fffffff;
        end else if (acc < SAT_MIN) begin
          moved[i] = 32'sh80000000;
        end else begin
          moved[i] = acc[31:0];
        end
      end
      res.px   = moved[0];
      res.py   = moved[1];
      res.pz   = moved[2];
      res.near = 1'b0;
    end
    return res;
  endfunction

  // Result check first, then the input transfer, then any settings write.
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_points.delete();
      quat_q[0]  = QUAT_ONE;
      quat_q[1]  = '0;
      quat_q[2]  = '0;
      quat_q[3]  = '0;
      shift_q[0] = '0;
      shift_q[1] = '0;
      shift_q[2] = '0;
      radius_q   = RADIUS_RESET;
      mismatches = 0;
      reported   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("unexpected result: x=%0d y=%0d z=%0d near=%0b",
                     out_x, out_y, out_z, out_near_self);
          end
        end else begin
          oldest = expected_points.pop_front();
          if (out_x !== oldest.px || out_y !== oldest.py || out_z !== oldest.pz ||
              out_near_self !== oldest.near) begin
            mismatches++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("mismatch: expected x=%0d y=%0d z=%0d near=%0b, got x=%0d y=%0d z=%0d near=%0b",
                       oldest.px, oldest.py, oldest.pz, oldest.near,
                       out_x, out_y, out_z, out_near_self);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        expected_points.push_back(predict_point(in_point_x, in_point_y, in_point_z));
      end

      // Bits above a register's width and unknown indexes are dropped.
      if (cfg_we) begin
        case (cfg_index)
          REG_QUAT_W:      quat_q[0]  = cfg_data[QUAT_W-1:0];
          REG_QUAT_X:      quat_q[1]  = cfg_data[QUAT_W-1:0];
          REG_QUAT_Y:      quat_q[2]  = cfg_data[QUAT_W-1:0];
          REG_QUAT_Z:      quat_q[3]  = cfg_data[QUAT_W-1:0];
          REG_SHIFT_X:     shift_q[0] = cfg_data[COORD_W-1:0];
          REG_SHIFT_Y:     shift_q[1] = cfg_data[COORD_W-1:0];
          REG_SHIFT_Z:     shift_q[2] = cfg_data[COORD_W-1:0];
          REG_SELF_RADIUS: radius_q   = cfg_data[RADIUS_W-1:0];
          default: begin
          end
        endcase
      end
    end
    mismatch_count <= mismatches;
    results_due    <= expected_points.size();
  end

endmodule

>>> verif/testbench.sv
// Stimulus and verdict for the point transform; the checker does the rest.
module testbench;
  import prtsf_pkg::*;

  localparam int unsigned NUM_REGS   = 8;
  localparam int LONG_HOLD_CYCLES    = 80;
  localparam int POINTS_PER_PHASE    = 50;
  localparam int RANDOM_PHASES       = 10;
  localparam int DRAIN_CYCLES        = 16;
  localparam int TIMEOUT_UNITS       = 2000000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH,
    IDLE_PRESSURE
  } idle_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_point_x;
  logic signed [COORD_W-1:0] in_point_y;
  logic signed [COORD_W-1:0] in_point_z;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      out_near_self;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  int mismatch_count;
  int results_due;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_rigid_transform_self_filter_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_near_self (out_near_self),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  point_transform_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_near_self  (out_near_self),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // Offer one point, idling first at random, and return at its transfer.
  task automatic send_point(input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py,
                            input logic signed [COORD_W-1:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes every register, with junk in the unused upper bits of the
  // quaternion and radius, then one write to an index past the register file.
  task automatic apply_settings(input prtsf_xform_t xf, input logic [RADIUS_W-1:0] radius);
    write_reg(REG_QUAT_W, {16'($urandom), xf.qw});
    write_reg(REG_QUAT_X, {16'($urandom), xf.qx});
    write_reg(REG_QUAT_Y, {16'($urandom), xf.qy});
    write_reg(REG_QUAT_Z, {16'($urandom), xf.qz});
    write_reg(REG_SHIFT_X, xf.sx);
    write_reg(REG_SHIFT_Y, xf.sy);
    write_reg(REG_SHIFT_Z, xf.sz);
    write_reg(REG_SELF_RADIUS, {1'($urandom), radius});
    write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(7)), $urandom);
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  function automatic logic signed [QUAT_W-1:0] pick_quat();
    case ($urandom_range(3))
      0: return QUAT_W'($urandom);
      1: begin
        case ($urandom_range(4))
          0:       return 16'sh8000;
          1:       return -16'sd16384;
          2:       return 16'sd0;
          3:       return 16'sd16384;
          default: return 16'sh7fff;
        endcase
      end
      2:       return $urandom_range(1) ? 16'sd11585 : -16'sd11585;
      default: return QUAT_W'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_shift();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return COORD_W'(int'($urandom_range(2097152)) - 1048576);
      2:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'sd0;
    endcase
  endfunction

  // One coordinate: full range, near the radius, extremes, or small.
  function automatic logic signed [COORD_W-1:0] pick_coord(input int kind, input longint lim);
    case (kind)
      0: return $urandom;
      1: return COORD_W'(longint'($urandom_range(32'(2 * lim))) - lim);
      2: begin
        case ($urandom_range(4))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sd0;
          3:       return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default: return COORD_W'(int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off when asked for one.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    prtsf_xform_t        xf;
    logic [RADIUS_W-1:0] radius;
    logic signed [COORD_W-1:0] c [3];
    idle_mode_t          mode;
    longint              lim;
    int                  phase, n, kind, axis;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_point_x     = '0;
    in_point_y     = '0;
    in_point_z     = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: origin, points on and just past the radius, extremes.
    send_point(32'sd0, 32'sd0, 32'sd0);
    send_point(32'sd15073, 32'sd0, 32'sd0);
    send_point(32'sd15074, 32'sd0, 32'sd0);
    send_point(32'sd0, -32'sd15073, 32'sd0);
    send_point(32'sd0, 32'sd0, -32'sd15074);
    send_point(32'sd8703, 32'sd8703, 32'sd8703);
    send_point(-32'sd1, -32'sd1, -32'sd1);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sd0);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    wait_idle();

    // Zero radius and a quaternion far off unit length, saturating shifts.
    xf = '{qw: 16'sh8000, qx: 16'sh7fff, qy: -16'sd16384, qz: 16'sd16384,
           sx: 32'sh7fffffff, sy: 32'sh80000000, sz: 32'sd0};
    apply_settings(xf, 31'd0);
    send_point(32'sd0, 32'sd0, 32'sd0);
    send_point(32'sd1, 32'sd0, 32'sd0);
    send_point(32'sd0, 32'sd0, -32'sd1);
    send_point(32'sd65536, -32'sd65536, 32'sd32768);
    send_point(32'sh7fffffff, 32'sd0, 32'sh80000000);
    send_point(32'sd123456789, -32'sd98765432, 32'sd55555);
    wait_idle();

    // Largest radius and a quarter turn about z.
    xf = '{qw: 16'sd11585, qx: 16'sd0, qy: 16'sd0, qz: 16'sd11585,
           sx: -32'sd327680, sy: 32'sd196608, sz: 32'sd1};
    apply_settings(xf, 31'h7fffffff);
    send_point(32'sh7fffffff, 32'sd0, 32'sd0);
    send_point(-32'sh7fffffff, 32'sd0, 32'sd0);
    send_point(32'sh80000000, 32'sd0, 32'sd0);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh40000000, 32'sh40000000, 32'sh40000000);
    send_point(32'sh60000000, 32'sh60000000, 32'sd0);
    wait_idle();

    // Random settings and points, cycling through the idling patterns.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = idle_mode_t'(phase % 5);
      case (mode)
        IDLE_SENDER: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        IDLE_BOTH: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if ($urandom_range(2) == 0) begin
        // Unit quarter turn about one axis.
        xf.qw = 16'sd11585;
        xf.qx = 16'sd0;
        xf.qy = 16'sd0;
        xf.qz = 16'sd0;
        case ($urandom_range(2))
          0:       xf.qx = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
          1:       xf.qy = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
          default: xf.qz = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
        endcase
      end else begin
        xf.qw = pick_quat();
        xf.qx = pick_quat();
        xf.qy = pick_quat();
        xf.qz = pick_quat();
      end
      xf.sx = pick_shift();
      xf.sy = pick_shift();
      xf.sz = pick_shift();
      case ($urandom_range(4))
        0:       radius = '0;
        1:       radius = 31'h7fffffff;
        2:       radius = RADIUS_W'($urandom);
        3:       radius = RADIUS_W'($urandom_range(1048576));
        default: radius = RADIUS_RESET;
      endcase
      apply_settings(xf, radius);

      lim = radius;
      if (lim > 64'sd1073741824) lim = 64'sd1073741824;

      // The long hold-off fills the block while points keep coming.
      if (mode == IDLE_PRESSURE) hold_request = 1'b1;

      for (n = 0; n < POINTS_PER_PHASE; n++) begin
        kind = $urandom_range(9);
        if (kind == 7) begin
          // One axis exactly on the radius or one step past it.
          axis = $urandom_range(2);
          c[0] = '0;
          c[1] = '0;
          c[2] = '0;
          c[axis] = COORD_W'(longint'(radius) + $urandom_range(1));
          if ($urandom_range(1)) c[axis] = -c[axis];
        end else begin
          kind = (kind <= 3) ? 0 : (kind <= 6) ? 1 : (kind == 8) ? 2 : 3;
          c[0] = pick_coord(kind, lim);
          c[1] = pick_coord(kind, lim);
          c[2] = pick_coord(kind, lim);
        end
        send_point(c[0], c[1], c[2]);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("point_rigid_transform_self_filter_top verification clean");
    end else begin
      $display("point_rigid_transform_self_filter_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_UNITS);
    $display("point_rigid_transform_self_filter_top verification failed");
    $finish;
  end

endmodule
